@@ design/mfb_pkg.sv @@
// Shared types and constants for the monochrome page frame buffer.
// Holds the opcode and sequencer enums, the panel command bytes and the stream widths.
// No dependencies.
package mfb_pkg;

  // Field and channel widths fixed by the item layout
  localparam int OPCODE_W  = 3;
  localparam int COORD_W   = 8;
  localparam int BYTE_W    = 8;
  localparam int OFFSET_W  = 7;
  localparam int S_TDATA_W = 48;
  // x of the last pixel of a bitmap byte: byte column * 8 + 7
  localparam int XL_W      = 11;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET  = 7'd4;
  localparam logic [BYTE_W-1:0]   CMD_PAGE_BASE = 8'hB0;
  localparam logic [BYTE_W-1:0]   CMD_COL_HIGH  = 8'h10;

  typedef enum logic [2:0] {
    OP_POINT   = 3'd0,
    OP_FILL    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_REFRESH = 3'd3,
    OP_BITMAP  = 3'd4,
    OP_TICK    = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_CLEAR,
    ST_REQ,
    ST_CMP,
    ST_CMP_LAST,
    ST_TICK,
    ST_EMIT
  } state_e;

endpackage

@@ design/mono_frame_buffer_draw_refresh.sv @@
// Monochrome page frame buffer with change-driven refresh stream; uses mfb_pkg and mfb_ram.
// Point and bitmap items: each touched store byte is read, modified and written back (read-modify-write).
// Fill: one read-modify-write per column and row block inside the panel, then a refresh request.
// Clear: one store byte per cycle (512 by default). Refresh: a decision state, then a
// compare-and-copy pass over the store bytes. Tick: the stream byte is read, then loaded into the output register.
// After reset a clearing pass zeroes both stores; no item is accepted meanwhile.
module mono_frame_buffer_draw_refresh #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], pen[32], pattern[40:33], zero fill
  input  logic [mfb_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // opcode[2:0]
  input  logic [mfb_pkg::OPCODE_W-1:0]    s_axis_tuser,
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_byte[7:0]
  output logic [mfb_pkg::BYTE_W-1:0]      m_axis_tdata,
  // is_data[0]
  output logic                            m_axis_tuser,
  // last
  output logic                            m_axis_tlast,
  // column offset register write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mfb_pkg::OFFSET_W-1:0]    cfg_data_i
);

  localparam int PAGES = PANEL_HEIGHT / 8;
  localparam int STORE = PANEL_WIDTH * PAGES;
  localparam int AW    = $clog2(STORE);
  localparam int CW    = $clog2(PANEL_WIDTH);
  localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int YW    = PGW + 3;
  localparam int KW    = $clog2(PANEL_WIDTH + 3);
  localparam int BW    = mfb_pkg::BYTE_W;

  localparam logic [mfb_pkg::XL_W-1:0]    X_MAX = mfb_pkg::XL_W'(PANEL_WIDTH - 1);
  localparam logic [mfb_pkg::COORD_W-1:0] Y_MAX = mfb_pkg::COORD_W'(PANEL_HEIGHT - 1);
  localparam logic [AW-1:0]  LAST_ADDR     = AW'(STORE - 1);
  localparam logic [PGW-1:0] LAST_PAGE     = PGW'(PAGES - 1);
  localparam logic [KW-1:0]  LAST_K        = KW'(PANEL_WIDTH + 2);
  localparam logic [KW-1:0]  FIRST_DATA_K  = KW'(3);
  localparam logic [CW-1:0]  OFF_MOD_RESET = CW'(4 % PANEL_WIDTH);

  // offset reduced modulo the panel width; at most eight subtract steps for a 7-bit offset
  function automatic logic [CW-1:0] offset_mod(input logic [mfb_pkg::OFFSET_W-1:0] v);
    logic [8:0] t;
    t = {2'b00, v};
    for (int i = 0; i < 8; i++) begin
      if (t >= 9'(PANEL_WIDTH)) begin
        t = t - 9'(PANEL_WIDTH);
      end
    end
    return t[CW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  mfb_pkg::state_e state_q, state_d;

  logic [AW-1:0]  cnt_q, cnt_d;          // sweep counter: init, clear, compare
  logic [AW-1:0]  addr_q, addr_d;        // write address, taken from the read address of the cycle before
  logic [CW-1:0]  x_q, x_d;              // current drawing column
  logic [CW-1:0]  x_hi_q, x_hi_d;
  logic [PGW-1:0] r_q, r_d;              // current row block (y / 8)
  logic [YW-1:0]  y_lo_q, y_lo_d;
  logic [YW-1:0]  y_hi_q, y_hi_d;
  logic           pen_q, pen_d;
  logic           bitmap_q, bitmap_d;
  logic [BW-1:0]  pat_q, pat_d;
  logic           fill_req_q, fill_req_d;
  logic           diff_q, diff_d;

  logic           stream_pending_q, stream_pending_d;
  logic           refresh_deferred_q, refresh_deferred_d;
  logic [PGW-1:0] sp_page_q, sp_page_d;
  logic [KW-1:0]  sp_k_q, sp_k_d;

  logic [mfb_pkg::OFFSET_W-1:0] cfg_off_q, cfg_off_d;
  logic [CW-1:0]                off_mod_q, off_mod_d;

  logic          out_valid_q, out_valid_d;
  logic [BW-1:0] out_data_q, out_data_d;
  logic          out_user_q, out_user_d;
  logic          out_last_q, out_last_d;

  // ---------------------------------------------------------------------------
  // Store RAM ports
  // ---------------------------------------------------------------------------
  logic          frm_we, frm_re, shd_we, shd_re;
  logic [AW-1:0] frm_waddr, frm_raddr, shd_waddr, shd_raddr;
  logic [BW-1:0] frm_wdata, shd_wdata, frm_rdata, shd_rdata;

  mfb_ram #(.WIDTH(BW), .DEPTH(STORE)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frm_we),
    .waddr_i (frm_waddr),
    .wdata_i (frm_wdata),
    .re_i    (frm_re),
    .raddr_i (frm_raddr),
    .rdata_o (frm_rdata)
  );

  mfb_ram #(.WIDTH(BW), .DEPTH(STORE)) u_shadow_ram (
    .clk_i   (clk_i),
    .we_i    (shd_we),
    .waddr_i (shd_waddr),
    .wdata_i (shd_wdata),
    .re_i    (shd_re),
    .raddr_i (shd_raddr),
    .rdata_o (shd_rdata)
  );

  // ---------------------------------------------------------------------------
  // Input item decode
  // ---------------------------------------------------------------------------
  mfb_pkg::op_e                op;
  logic [mfb_pkg::COORD_W-1:0] xs, ys, xe, ye;
  logic                        in_pen;
  logic [BW-1:0]               in_pat;
  logic                        in_acc;
  logic [mfb_pkg::XL_W-1:0]    x_lo_w, x_hi_raw, x_hi_w;
  logic [mfb_pkg::COORD_W-1:0] y_hi_raw, y_hi_w;
  logic                        draw_empty;

  assign op     = mfb_pkg::op_e'(s_axis_tuser);
  assign xs     = s_axis_tdata[7:0];
  assign ys     = s_axis_tdata[15:8];
  assign xe     = s_axis_tdata[23:16];
  assign ye     = s_axis_tdata[31:24];
  assign in_pen = s_axis_tdata[32];
  assign in_pat = s_axis_tdata[40:33];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Point, fill and bitmap byte all become a clipped rectangle walked column by column.
  // A bitmap byte spans eight columns of one row; a point is a one-pixel rectangle.
  always_comb begin
    if (op == mfb_pkg::OP_BITMAP) begin
      x_lo_w   = {xs, 3'b000};
      x_hi_raw = {xs, 3'b111};
    end else begin
      x_lo_w   = {3'b000, xs};
      x_hi_raw = (op == mfb_pkg::OP_FILL) ? {3'b000, xe} : {3'b000, xs};
    end
    y_hi_raw   = (op == mfb_pkg::OP_FILL) ? ye : ys;
    x_hi_w     = (x_hi_raw > X_MAX) ? X_MAX : x_hi_raw;
    y_hi_w     = (y_hi_raw > Y_MAX) ? Y_MAX : y_hi_raw;
    // start beyond the clipped end: nothing on the panel to touch
    draw_empty = (x_lo_w > x_hi_w) || (ys > y_hi_w);
  end

  // ---------------------------------------------------------------------------
  // Shared read-modify-write unit: column remap, byte address, row mask
  // ---------------------------------------------------------------------------
  logic [CW-1:0]  col_w;
  logic [PGW-1:0] page_w;
  logic [AW-1:0]  fill_addr_w;
  logic [BW-1:0]  mask_w;
  logic [YW-1:0]  row_w [BW];
  logic           draw_pen;
  logic [BW-1:0]  draw_byte;
  logic [PGW-1:0] r_lo, r_hi;
  logic           draw_done;

  assign r_lo = y_lo_q[YW-1:3];
  assign r_hi = y_hi_q[YW-1:3];

  always_comb begin
    if (x_q >= off_mod_q) begin
      col_w = x_q - off_mod_q;
    end else begin
      col_w = CW'({1'b0, x_q} + (CW+1)'(PANEL_WIDTH) - {1'b0, off_mod_q});
    end
  end

  // pages run bottom-up: row block 0 sits in the last page
  assign page_w      = LAST_PAGE - r_q;
  assign fill_addr_w = AW'(col_w) * AW'(PAGES) + AW'(page_w);

  // bit b of a page byte holds row 8*r + 7 - b
  always_comb begin
    for (int b = 0; b < BW; b++) begin
      row_w[b]  = {r_q, 3'(7 - b)};
      mask_w[b] = (row_w[b] >= y_lo_q) && (row_w[b] <= y_hi_q);
    end
  end

  assign draw_pen  = bitmap_q ? pat_q[0] : pen_q;
  assign draw_byte = draw_pen ? (frm_rdata | mask_w) : (frm_rdata & ~mask_w);
  assign draw_done = (x_q == x_hi_q) && (r_q == r_hi);

  // ---------------------------------------------------------------------------
  // Refresh stream byte
  // ---------------------------------------------------------------------------
  logic [AW-1:0] stream_addr_w;
  logic          stream_is_data;
  logic          stream_last;
  logic [BW-1:0] stream_byte;
  logic          out_free;
  logic          cnt_last;

  assign stream_addr_w  = AW'(sp_k_q - FIRST_DATA_K) * AW'(PAGES) + AW'(sp_page_q);
  assign stream_is_data = (sp_k_q >= FIRST_DATA_K);
  assign stream_last    = (sp_page_q == LAST_PAGE) && (sp_k_q == LAST_K);

  always_comb begin
    if (sp_k_q == KW'(0)) begin
      stream_byte = mfb_pkg::CMD_PAGE_BASE + BW'(sp_page_q);
    end else if (sp_k_q == KW'(1)) begin
      stream_byte = {4'h0, cfg_off_q[3:0]};
    end else if (sp_k_q == KW'(2)) begin
      stream_byte = mfb_pkg::CMD_COL_HIGH | {5'b00000, cfg_off_q[6:4]};
    end else begin
      stream_byte = shd_rdata;
    end
  end

  // a result may be loaded when the output register is empty or being drained
  assign out_free = !out_valid_q || m_axis_tready;
  assign cnt_last = (cnt_q == LAST_ADDR);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfb_pkg::ST_INIT: begin
        if (cnt_last) state_d = mfb_pkg::ST_IDLE;
      end
      mfb_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            mfb_pkg::OP_POINT, mfb_pkg::OP_BITMAP: begin
              if (!draw_empty) state_d = mfb_pkg::ST_FILL_RD;
            end
            mfb_pkg::OP_FILL: begin
              state_d = draw_empty ? mfb_pkg::ST_REQ : mfb_pkg::ST_FILL_RD;
            end
            mfb_pkg::OP_CLEAR:   state_d = mfb_pkg::ST_CLEAR;
            mfb_pkg::OP_REFRESH: state_d = mfb_pkg::ST_REQ;
            mfb_pkg::OP_TICK: begin
              if (stream_pending_q) state_d = mfb_pkg::ST_TICK;
            end
            default: state_d = mfb_pkg::ST_IDLE;
          endcase
        end
      end
      mfb_pkg::ST_FILL_RD: state_d = mfb_pkg::ST_FILL_WR;
      mfb_pkg::ST_FILL_WR: begin
        if (draw_done) begin
          state_d = fill_req_q ? mfb_pkg::ST_REQ : mfb_pkg::ST_IDLE;
        end else begin
          state_d = mfb_pkg::ST_FILL_RD;
        end
      end
      mfb_pkg::ST_CLEAR: begin
        if (cnt_last) state_d = mfb_pkg::ST_REQ;
      end
      mfb_pkg::ST_REQ: begin
        state_d = stream_pending_q ? mfb_pkg::ST_IDLE : mfb_pkg::ST_CMP;
      end
      mfb_pkg::ST_CMP: begin
        if (cnt_last) state_d = mfb_pkg::ST_CMP_LAST;
      end
      mfb_pkg::ST_CMP_LAST: state_d = mfb_pkg::ST_IDLE;
      mfb_pkg::ST_TICK:     state_d = mfb_pkg::ST_EMIT;
      mfb_pkg::ST_EMIT: begin
        if (out_free) begin
          // a deferred request is evaluated right after the final byte
          state_d = (stream_last && refresh_deferred_q) ? mfb_pkg::ST_REQ : mfb_pkg::ST_IDLE;
        end
      end
      default: state_d = mfb_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath controls and register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_d              = cnt_q;
    addr_d             = addr_q;
    x_d                = x_q;
    x_hi_d             = x_hi_q;
    r_d                = r_q;
    y_lo_d             = y_lo_q;
    y_hi_d             = y_hi_q;
    pen_d              = pen_q;
    bitmap_d           = bitmap_q;
    pat_d              = pat_q;
    fill_req_d         = fill_req_q;
    diff_d             = diff_q;
    stream_pending_d   = stream_pending_q;
    refresh_deferred_d = refresh_deferred_q;
    sp_page_d          = sp_page_q;
    sp_k_d             = sp_k_q;
    out_valid_d        = out_valid_q;
    out_data_d         = out_data_q;
    out_user_d         = out_user_q;
    out_last_d         = out_last_q;

    frm_we    = 1'b0;
    frm_waddr = cnt_q;
    frm_wdata = '0;
    frm_re    = 1'b0;
    frm_raddr = cnt_q;
    shd_we    = 1'b0;
    shd_waddr = addr_q;
    shd_wdata = frm_rdata;
    shd_re    = 1'b0;
    shd_raddr = cnt_q;

    // drain the output register
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mfb_pkg::ST_INIT: begin
        // zero both stores, one byte a cycle
        frm_we    = 1'b1;
        shd_we    = 1'b1;
        shd_waddr = cnt_q;
        shd_wdata = '0;
        cnt_d     = cnt_last ? '0 : cnt_q + AW'(1);
      end
      mfb_pkg::ST_IDLE: begin
        if (in_acc) begin
          cnt_d      = '0;
          x_d        = x_lo_w[CW-1:0];
          x_hi_d     = x_hi_w[CW-1:0];
          y_lo_d     = ys[YW-1:0];
          y_hi_d     = y_hi_w[YW-1:0];
          r_d        = ys[YW-1:3];
          pen_d      = in_pen;
          pat_d      = in_pat;
          bitmap_d   = (op == mfb_pkg::OP_BITMAP);
          fill_req_d = (op == mfb_pkg::OP_FILL);
        end
      end
      mfb_pkg::ST_FILL_RD: begin
        frm_re    = 1'b1;
        frm_raddr = fill_addr_w;
        addr_d    = fill_addr_w;
      end
      mfb_pkg::ST_FILL_WR: begin
        frm_we    = 1'b1;
        frm_waddr = addr_q;
        frm_wdata = draw_byte;
        // advance down the column's row blocks, then to the next column
        if (r_q == r_hi) begin
          r_d   = r_lo;
          x_d   = x_q + CW'(1);
          pat_d = pat_q >> 1;
        end else begin
          r_d = r_q + PGW'(1);
        end
      end
      mfb_pkg::ST_CLEAR: begin
        frm_we = 1'b1;
        cnt_d  = cnt_last ? '0 : cnt_q + AW'(1);
      end
      mfb_pkg::ST_REQ: begin
        if (stream_pending_q) begin
          refresh_deferred_d = 1'b1;
        end else begin
          cnt_d  = '0;
          diff_d = 1'b0;
        end
      end
      mfb_pkg::ST_CMP: begin
        // read both stores; copy and compare the byte read in the previous cycle
        frm_re = 1'b1;
        shd_re = 1'b1;
        addr_d = cnt_q;
        if (cnt_q != '0) begin
          shd_we = 1'b1;
          diff_d = diff_q | (frm_rdata != shd_rdata);
        end
        cnt_d = cnt_last ? '0 : cnt_q + AW'(1);
      end
      mfb_pkg::ST_CMP_LAST: begin
        shd_we = 1'b1;
        if (diff_q || (frm_rdata != shd_rdata)) begin
          stream_pending_d = 1'b1;
          sp_page_d        = '0;
          sp_k_d           = '0;
        end
      end
      mfb_pkg::ST_TICK: begin
        shd_re    = 1'b1;
        shd_raddr = stream_addr_w;
      end
      mfb_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = stream_byte;
          out_user_d  = stream_is_data;
          out_last_d  = stream_last;
          if (stream_last) begin
            stream_pending_d   = 1'b0;
            refresh_deferred_d = 1'b0;
            sp_page_d          = '0;
            sp_k_d             = '0;
          end else if (sp_k_q == LAST_K) begin
            sp_k_d    = '0;
            sp_page_d = sp_page_q + PGW'(1);
          end else begin
            sp_k_d = sp_k_q + KW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // configuration register, taken at any time
  always_comb begin
    cfg_off_d = cfg_off_q;
    off_mod_d = off_mod_q;
    if (cfg_valid_i) begin
      cfg_off_d = cfg_data_i;
      off_mod_d = offset_mod(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= mfb_pkg::ST_INIT;
      cnt_q              <= '0;
      stream_pending_q   <= 1'b0;
      refresh_deferred_q <= 1'b0;
      sp_page_q          <= '0;
      sp_k_q             <= '0;
      out_valid_q        <= 1'b0;
      cfg_off_q          <= mfb_pkg::OFFSET_RESET;
      off_mod_q          <= OFF_MOD_RESET;
    end else begin
      state_q            <= state_d;
      cnt_q              <= cnt_d;
      stream_pending_q   <= stream_pending_d;
      refresh_deferred_q <= refresh_deferred_d;
      sp_page_q          <= sp_page_d;
      sp_k_q             <= sp_k_d;
      out_valid_q        <= out_valid_d;
      cfg_off_q          <= cfg_off_d;
      off_mod_q          <= off_mod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    x_q        <= x_d;
    x_hi_q     <= x_hi_d;
    r_q        <= r_d;
    y_lo_q     <= y_lo_d;
    y_hi_q     <= y_hi_d;
    pen_q      <= pen_d;
    bitmap_q   <= bitmap_d;
    pat_q      <= pat_d;
    fill_req_q <= fill_req_d;
    diff_q     <= diff_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state_q == mfb_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;
  assign cfg_ready_o   = 1'b1;

`ifndef SYNTH
  // a deferred request only exists while a stream is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    refresh_deferred_q |-> stream_pending_q)
    else $error("refresh deferred without a running stream");

  // tick handling only ever runs on a live stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mfb_pkg::ST_TICK || state_q == mfb_pkg::ST_EMIT) |-> stream_pending_q)
    else $error("stream byte produced with no stream pending");

  // byte position within a page run stays inside the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stream_pending_q |-> (sp_k_q <= LAST_K))
    else $error("stream position beyond the page run");
`endif

endmodule

@@ design/mfb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the frame and shadow stores. No dependencies.
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read word while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
